@@ rtl/bns_pkg.sv @@
// Shared types, constants and helper functions for the BGRA to NV12 scaler.
// Used by every module of the block; depends on nothing.

package bns_pkg;

  // Field widths
  localparam int DIM_W    = 13;  // size registers and output position counters
  localparam int ACC_W    = 25;  // scale accumulators
  localparam int POS_W    = 12;  // output column and row fields
  localparam int PITCH_W  = 14;  // even-rounded output width
  localparam int SUM_W    = 18;  // signed color dot products
  localparam int LOFF_W   = 24;
  localparam int COFF_W   = 25;
  localparam int YP_W     = POS_W + PITCH_W;
  localparam int HP_W     = POS_W - 1 + PITCH_W;
  localparam int BASE_W   = PITCH_W + DIM_W;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 104;

  // Configuration register indexes
  localparam logic [1:0] REG_SRC_W = 2'd0;
  localparam logic [1:0] REG_SRC_H = 2'd1;
  localparam logic [1:0] REG_OUT_W = 2'd2;
  localparam logic [1:0] REG_OUT_H = 2'd3;

  // Configuration reset values
  localparam logic [DIM_W-1:0] RST_SRC_W = 13'd1920;
  localparam logic [DIM_W-1:0] RST_SRC_H = 13'd1080;
  localparam logic [DIM_W-1:0] RST_OUT_W = 13'd1920;
  localparam logic [DIM_W-1:0] RST_OUT_H = 13'd1080;

  // BT.601 studio-range coefficients
  localparam logic signed [SUM_W-1:0] K_YR = 18'sd66;
  localparam logic signed [SUM_W-1:0] K_YG = 18'sd129;
  localparam logic signed [SUM_W-1:0] K_YB = 18'sd25;
  localparam logic signed [SUM_W-1:0] K_UR = -18'sd38;
  localparam logic signed [SUM_W-1:0] K_UG = -18'sd74;
  localparam logic signed [SUM_W-1:0] K_UB = 18'sd112;
  localparam logic signed [SUM_W-1:0] K_VR = 18'sd112;
  localparam logic signed [SUM_W-1:0] K_VG = -18'sd94;
  localparam logic signed [SUM_W-1:0] K_VB = -18'sd18;
  localparam logic signed [SUM_W-1:0] K_ROUND = 18'sd128;
  localparam logic signed [SUM_W-1:0] K_CBIAS = 18'sd32768;  // 128 << 8
  localparam logic signed [SUM_W-1:0] K_YOFF  = 18'sd16;
  localparam logic signed [SUM_W-1:0] K_MAXB  = 18'sd255;

  // Effective frame geometry
  typedef struct packed {
    logic [DIM_W-1:0]   sw;
    logic [DIM_W-1:0]   sh;
    logic [DIM_W-1:0]   ow;
    logic [DIM_W-1:0]   oh;
    logic [PITCH_W-1:0] pitch;
  } dims_t;

  // One picked pixel on its way from front to back
  typedef struct packed {
    logic [7:0]       blue;
    logic [7:0]       green;
    logic [7:0]       red;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic             cv;
    logic             fe;
  } item_t;

  // Queue status seen by the top level and the back end
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // First back stage: products and sums
  typedef struct packed {
    logic signed [SUM_W-1:0] ysum;
    logic signed [SUM_W-1:0] usum;
    logic signed [SUM_W-1:0] vsum;
    logic [YP_W-1:0]         yp;
    logic [HP_W-1:0]         hp;
    logic [BASE_W-1:0]       base;
    logic [POS_W-1:0]        x;
    logic [POS_W-1:0]        y;
    logic                    cv;
    logic                    fe;
  } stage_t;

  // Saturate a size to 1..hi
  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W:0] hi);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if ({1'b0, v} > hi) begin
      r = hi[DIM_W-1:0];
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Clamp a signed value to one byte
  function automatic logic [7:0] clamp_byte(input logic signed [SUM_W-1:0] v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > K_MAXB) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/bns_front.sv @@
// Front end: tracks source position, picks output pixels by nearest neighbour.
// Depends on bns_pkg; feeds picked pixels into bns_queue.

module bns_front import bns_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic      clk,
  input  logic      rst,
  input  dims_t     dims,
  input  logic      accept,
  input  logic      frame_start,
  input  logic [7:0] blue,
  input  logic [7:0] green,
  input  logic [7:0] red,
  output logic      push,
  output item_t     push_data
);

  localparam int SCW = $clog2(MAX_WIDTH);
  localparam int SRW = $clog2(MAX_HEIGHT);

  logic [SCW-1:0]   src_col, src_col_next, c_sc;
  logic [SRW-1:0]   src_row, src_row_next, c_sr;
  logic [DIM_W-1:0] out_col, out_col_next, c_oc;
  logic [DIM_W-1:0] out_row, out_row_next, c_or;
  logic [ACC_W-1:0] cta, cta_next, c_cta;
  logic [ACC_W-1:0] csa, csa_next, c_csa;
  logic [ACC_W-1:0] rta, rta_next, c_rta;
  logic [ACC_W-1:0] rsa, rsa_next, c_rsa;
  logic             row_pick, col_pick;

  // Decide the pick and the next position
  always_comb begin
    c_sc = src_col;  c_sr = src_row;
    c_oc = out_col;  c_or = out_row;
    c_cta = cta;     c_csa = csa;
    c_rta = rta;     c_rsa = rsa;
    if (frame_start) begin
      c_sc = '0;  c_sr = '0;  c_oc = '0;  c_or = '0;
      c_cta = '0; c_csa = '0; c_rta = '0; c_rsa = '0;
    end

    row_pick = (c_or < dims.oh) &&
               ({1'b0, c_rta} < ({1'b0, c_rsa} + (ACC_W+1)'(dims.oh)));
    col_pick = (c_oc < dims.ow) &&
               ({1'b0, c_cta} < ({1'b0, c_csa} + (ACC_W+1)'(dims.ow)));

    src_col_next = c_sc;  src_row_next = c_sr;
    out_col_next = c_oc;  out_row_next = c_or;
    cta_next = c_cta;     rta_next = c_rta;     rsa_next = c_rsa;

    if (col_pick) begin
      out_col_next = c_oc + DIM_W'(1);
      cta_next     = c_cta + ACC_W'(dims.sw);
    end
    csa_next = c_csa + ACC_W'(dims.ow);

    // End of source row, and of frame
    if (DIM_W'(c_sc) >= dims.sw - DIM_W'(1)) begin
      src_col_next = '0;
      out_col_next = '0;
      cta_next     = '0;
      csa_next     = '0;
      if (DIM_W'(c_sr) >= dims.sh - DIM_W'(1)) begin
        src_row_next = '0;
        out_row_next = '0;
        rta_next     = '0;
        rsa_next     = '0;
      end else begin
        if (row_pick) begin
          out_row_next = c_or + DIM_W'(1);
          rta_next     = c_rta + ACC_W'(dims.sh);
        end
        rsa_next     = c_rsa + ACC_W'(dims.oh);
        src_row_next = c_sr + SRW'(1);
      end
    end else begin
      src_col_next = c_sc + SCW'(1);
    end
  end

  // Build the request for the back end
  always_comb begin
    push            = accept && row_pick && col_pick;
    push_data.blue  = blue;
    push_data.green = green;
    push_data.red   = red;
    push_data.x     = c_oc[POS_W-1:0];
    push_data.y     = c_or[POS_W-1:0];
    push_data.cv    = !c_oc[0] && !c_or[0] &&
                      ((c_oc >> 1) < (dims.ow >> 1)) &&
                      ((c_or >> 1) < (dims.oh >> 1));
    push_data.fe    = (c_oc == dims.ow - DIM_W'(1)) &&
                      (c_or == dims.oh - DIM_W'(1));
  end

  // Advance position on each accepted pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      src_col <= '0;  src_row <= '0;
      out_col <= '0;  out_row <= '0;
      cta <= '0;      csa <= '0;
      rta <= '0;      rsa <= '0;
    end else if (accept) begin
      src_col <= src_col_next;  src_row <= src_row_next;
      out_col <= out_col_next;  out_row <= out_row_next;
      cta <= cta_next;          csa <= csa_next;
      rta <= rta_next;          rsa <= rsa_next;
    end
  end

endmodule

@@ rtl/bns_queue.sv @@
// Short flip-flop queue between the front and back ends.
// Depends on bns_pkg for the item and status types.

module bns_queue import bns_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  item_t     push_data,
  input  logic      pop,
  output item_t     pop_data,
  output q_status_t status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          slots [DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push, do_pop;

  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = slots[rd_ptr];

  // Store incoming requests
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ rtl/bns_back.sv @@
// Back end: color conversion and NV12 offsets in two stages, output register last.
// Depends on bns_pkg; drains bns_queue.

module bns_back import bns_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  dims_t                 dims,
  input  q_status_t             q_status,
  input  item_t                 q_data,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast,
  output logic                  m_tuser
);

  logic                    advance;
  logic                    s1_valid;
  stage_t                  s1, s1_next;
  logic signed [SUM_W-1:0] rs, gs, bs;
  logic [7:0]              luma, cb, cr;
  logic [LOFF_W-1:0]       luma_off;
  logic [COFF_W-1:0]       chroma_off;

  assign advance = !m_tvalid || m_tready;
  assign q_pop   = advance && !q_status.empty;

  // Stage one: dot products and offset products
  always_comb begin
    rs = SUM_W'(q_data.red);
    gs = SUM_W'(q_data.green);
    bs = SUM_W'(q_data.blue);
    s1_next.ysum = K_YR * rs + K_YG * gs + K_YB * bs + K_ROUND;
    s1_next.usum = K_UR * rs + K_UG * gs + K_UB * bs + K_ROUND + K_CBIAS;
    s1_next.vsum = K_VR * rs + K_VG * gs + K_VB * bs + K_ROUND + K_CBIAS;
    s1_next.yp   = YP_W'(q_data.y) * YP_W'(dims.pitch);
    s1_next.hp   = HP_W'(q_data.y[POS_W-1:1]) * HP_W'(dims.pitch);
    s1_next.base = BASE_W'(dims.pitch) * BASE_W'(dims.oh);
    s1_next.x    = q_data.x;
    s1_next.y    = q_data.y;
    s1_next.cv   = q_data.cv;
    s1_next.fe   = q_data.fe;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= !q_status.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1 <= s1_next;
    end
  end

  // Stage two: shift, clamp, add offsets
  always_comb begin
    luma       = clamp_byte((s1.ysum >>> 8) + K_YOFF);
    cb         = s1.cv ? clamp_byte(s1.usum >>> 8) : 8'd0;
    cr         = s1.cv ? clamp_byte(s1.vsum >>> 8) : 8'd0;
    luma_off   = LOFF_W'(s1.yp + YP_W'(s1.x));
    chroma_off = s1.cv ? COFF_W'(s1.base + BASE_W'(s1.hp) + BASE_W'(s1.x)) : '0;
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {7'd0, chroma_off, cr, cb, luma_off, luma, s1.y, s1.x};
      m_tlast <= s1.fe;
      m_tuser <= s1.cv;
    end
  end

endmodule

@@ rtl/bgra_to_nv12_scaler.sv @@
// BGRA to NV12 nearest-neighbour downscaler, top level.
// A picked pixel passes the four-entry queue, the stage-one and the output register.
// Throughput: one source pixel per cycle while the queue has room; it decouples pick logic
// from the two-stage conversion pipeline, whose output register sets the stall point.
// Reset (rst, synchronous): position state and pipeline clear, sizes 1920x1080 in and out.
// Depends on bns_pkg, bns_front, bns_queue and bns_back.

module bgra_to_nv12_scaler import bns_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [DIM_W-1:0]      cfg_data,
  // Source pixels
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // blue[7:0], green[15:8], red[23:16]
  input  logic                  s_tuser,   // frame_start
  // Output samples
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // out_column[11:0], out_row[23:12],
                                           // luma[31:24], luma_offset[55:32],
                                           // cb[63:56], cr[71:64],
                                           // chroma_offset[96:72], zero pad
  output logic                  m_tlast,   // frame_end
  output logic                  m_tuser    // chroma_valid
);

  logic [DIM_W-1:0] src_w, src_h, out_w, out_h;
  dims_t            dims;
  logic             accept, push;
  item_t            push_data, q_data;
  q_status_t        q_status;
  logic             q_pop;

  // Size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_w <= RST_SRC_W;
      src_h <= RST_SRC_H;
      out_w <= RST_OUT_W;
      out_h <= RST_OUT_H;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SRC_W: src_w <= cfg_data;
        REG_SRC_H: src_h <= cfg_data;
        REG_OUT_W: out_w <= cfg_data;
        REG_OUT_H: out_h <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective geometry
  always_comb begin
    dims.sw    = sat_dim(src_w, (DIM_W+1)'(MAX_WIDTH));
    dims.sh    = sat_dim(src_h, (DIM_W+1)'(MAX_HEIGHT));
    dims.ow    = sat_dim(out_w, {1'b0, dims.sw});
    dims.oh    = sat_dim(out_h, {1'b0, dims.sh});
    dims.pitch = PITCH_W'(dims.ow) + PITCH_W'(dims.ow[0]);
  end

  assign s_tready = !q_status.full;
  assign accept   = s_tvalid && s_tready;

  bns_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .dims        (dims),
    .accept      (accept),
    .frame_start (s_tuser),
    .blue        (s_tdata[7:0]),
    .green       (s_tdata[15:8]),
    .red         (s_tdata[23:16]),
    .push        (push),
    .push_data   (push_data)
  );

  bns_queue #(
    .DEPTH (4)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (q_data),
    .status    (q_status)
  );

  bns_back u_back (
    .clk      (clk),
    .rst      (rst),
    .dims     (dims),
    .q_status (q_status),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

@@ rtl/bns_checker.sv @@
// Port-level checks for the BGRA to NV12 scaler, bound to the top level.
// Depends on bns_pkg.

module bns_checker import bns_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tlast,
  input logic                  m_tuser
);

  // A stalled result stays offered and unchanged
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("stalled result changed");

  // Chroma goes out only at even column and row
  a_chroma_even: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !m_tdata[0] && !m_tdata[12])
    else $error("chroma at odd position");

  // Without chroma, its fields read zero
  a_chroma_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[96:56] == '0)
    else $error("chroma fields set without chroma");

  // Reset empties the output
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result offered right after reset");

endmodule

bind bgra_to_nv12_scaler bns_checker u_bns_checker (.*);

@@ test/bns_sample_checker.sv @@
// Sample checker for the BGRA to NV12 scaler: watches the config port and both streams,
// predicts every output sample from the accepted pixels and compares field by field.
// Depends on bns_pkg for widths, register indexes and reset sizes.

module bns_sample_checker import bns_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [DIM_W-1:0]      cfg_data,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  m_tlast,
  input  logic                  m_tuser,
  output int                    mismatch_total,
  output int                    samples_due
);

  typedef struct packed {
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  row;
    logic [7:0]        luma;
    logic [LOFF_W-1:0] luma_off;
    logic              chroma_on;
    logic [7:0]        cb;
    logic [7:0]        cr;
    logic [COFF_W-1:0] chroma_off;
    logic              last;
  } nv12_sample_t;

  // Size registers as written
  logic [DIM_W-1:0] size_src_w, size_src_h, size_out_w, size_out_h;

  // Scan position and nearest-neighbour accumulators
  logic [POS_W-1:0] src_col, src_row;
  logic [DIM_W-1:0] out_col_next, out_row_next;
  logic [ACC_W-1:0] col_tgt, col_src, row_tgt, row_src;
  logic             row_hit;

  nv12_sample_t pending_samples[$];
  int           mismatches = 0;

  function automatic int unsigned fit_size(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic [7:0] to_byte(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  task automatic rewind_frame();
    src_col = '0;
    src_row = '0;
    out_col_next = '0;
    out_row_next = '0;
    col_tgt = '0;
    col_src = '0;
    row_tgt = '0;
    row_src = '0;
    row_hit = 1'b0;
  endtask

  // Advance the scan by one source pixel; return the sample it picks, if any
  task automatic scale_pixel(input logic [IN_DATA_W-1:0] pix, input logic first,
                             output logic hit, output nv12_sample_t s);
    int unsigned sw, sh, ow, oh, pitch, x, y;
    int          bi, gi, ri, ys, us, vs;
    logic        col_hit, last_row;
    sw = fit_size(size_src_w, MAX_WIDTH);
    sh = fit_size(size_src_h, MAX_HEIGHT);
    ow = fit_size(size_out_w, sw);
    oh = fit_size(size_out_h, sh);
    pitch = (ow + 1) & ~32'd1;
    bi = {24'd0, pix[7:0]};
    gi = {24'd0, pix[15:8]};
    ri = {24'd0, pix[23:16]};
    s = '0;

    if (first) rewind_frame();

    row_hit = (out_row_next < oh) && (row_tgt < row_src + oh);
    col_hit = (out_col_next < ow) && (col_tgt < col_src + ow);
    hit = row_hit && col_hit;

    if (hit) begin
      x = out_col_next;
      y = out_row_next;
      ys = 66 * ri + 129 * gi + 25 * bi + 128;
      s.col = POS_W'(x);
      s.row = POS_W'(y);
      s.luma = to_byte((ys >>> 8) + 16);
      s.luma_off = LOFF_W'(y * pitch + x);
      // chroma only on even positions inside the even-trimmed area
      s.chroma_on = ((x | y) & 1) == 0 && (x >> 1) < (ow >> 1) && (y >> 1) < (oh >> 1);
      if (s.chroma_on) begin
        us = -38 * ri - 74 * gi + 112 * bi + 128 + 32768;
        vs = 112 * ri - 94 * gi - 18 * bi + 128 + 32768;
        s.cb = to_byte(us >>> 8);
        s.cr = to_byte(vs >>> 8);
        s.chroma_off = COFF_W'(pitch * oh + (y >> 1) * pitch + x);
      end
      s.last = (x == ow - 1) && (y == oh - 1);
    end
    if (col_hit) begin
      out_col_next = out_col_next + 1'b1;
      col_tgt = ACC_W'(col_tgt + sw);
    end
    col_src = ACC_W'(col_src + ow);

    // Wrap at end of row, and at end of frame
    if (src_col >= sw - 1) begin
      last_row = src_row >= sh - 1;
      src_col = '0;
      out_col_next = '0;
      col_tgt = '0;
      col_src = '0;
      if (last_row) begin
        rewind_frame();
      end else begin
        if (row_hit) begin
          out_row_next = out_row_next + 1'b1;
          row_tgt = ACC_W'(row_tgt + sh);
        end
        row_src = ACC_W'(row_src + oh);
        src_row = src_row + 1'b1;
      end
    end else begin
      src_col = src_col + 1'b1;
    end
  endtask

  task automatic log_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) log_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin : watch
    logic         hit;
    nv12_sample_t want, got;
    if (rst) begin
      size_src_w = RST_SRC_W;
      size_src_h = RST_SRC_H;
      size_out_w = RST_OUT_W;
      size_out_h = RST_OUT_H;
      rewind_frame();
      pending_samples.delete();
    end else begin
      // Track register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SRC_W: size_src_w = cfg_data;
          REG_SRC_H: size_src_h = cfg_data;
          REG_OUT_W: size_out_w = cfg_data;
          REG_OUT_H: size_out_h = cfg_data;
          default: ;
        endcase
      end

      // Predict from each accepted pixel request
      if (s_tvalid && s_tready) begin
        scale_pixel(s_tdata, s_tuser, hit, want);
        if (hit) pending_samples.push_back(want);
      end

      // Compare each accepted sample with the oldest prediction
      if (m_tvalid && m_tready) begin
        got.col        = m_tdata[11:0];
        got.row        = m_tdata[23:12];
        got.luma       = m_tdata[31:24];
        got.luma_off   = m_tdata[55:32];
        got.cb         = m_tdata[63:56];
        got.cr         = m_tdata[71:64];
        got.chroma_off = m_tdata[96:72];
        got.chroma_on  = m_tuser;
        got.last       = m_tlast;
        if (pending_samples.size() == 0) begin
          log_mismatch($sformatf("sample col %0d row %0d with none expected",
                                 got.col, got.row));
        end else begin
          want = pending_samples.pop_front();
          check_field("out_column", got.col, want.col);
          check_field("out_row", got.row, want.row);
          check_field("luma", got.luma, want.luma);
          check_field("luma_offset", got.luma_off, want.luma_off);
          check_field("chroma_valid", got.chroma_on, want.chroma_on);
          check_field("cb", got.cb, want.cb);
          check_field("cr", got.cr, want.cr);
          check_field("chroma_offset", got.chroma_off, want.chroma_off);
          check_field("frame_end", got.last, want.last);
          check_field("tdata pad", m_tdata[OUT_DATA_W-1:97], 0);
        end
      end
    end
    samples_due <= pending_samples.size();
    mismatch_total <= mismatches;
  end

endmodule

@@ test/bgra_to_nv12_scaler_tb.sv @@
// Testbench top for the BGRA to NV12 scaler: drives sizes and pixel frames under
// random idling and stalls, and gives the verdict from bns_sample_checker's count.
// Depends on bns_pkg, bgra_to_nv12_scaler and bns_sample_checker.

module bgra_to_nv12_scaler_tb;
  import bns_pkg::*;

  localparam int PIPE_LAT     = 3;
  localparam int RANDOM_ITEMS = 500;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [1:0]            cfg_index = REG_SRC_W;
  logic [DIM_W-1:0]      cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  m_tuser;

  int mismatch_total;
  int samples_due;
  int send_idle_pct = 33;
  int recv_stall_pct = 62;
  int pixels_sent = 0;

  bgra_to_nv12_scaler dut (
    .clk, .rst, .cfg_wr_en, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser
  );

  bns_sample_checker chk (
    .clk, .rst, .cfg_wr_en, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser,
    .mismatch_total, .samples_due
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the sample side at random
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one pixel request, idling first at random, and hold it until taken
  task automatic send_pixel(input logic [7:0] b, g, r, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {r, g, b};
    s_tuser <= first;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic send_random(input logic first);
    logic [23:0] c;
    c = 24'($urandom);
    send_pixel(c[7:0], c[15:8], c[23:16], first);
  endtask

  // Drop valid and wait until every predicted sample is out and the pipe is empty
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (samples_due != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[DIM_W-1:0];
    @(posedge clk);
  endtask

  task automatic set_sizes(input int unsigned sw, sh, ow, oh);
    write_reg(REG_SRC_W, sw);
    write_reg(REG_SRC_H, sh);
    write_reg(REG_OUT_W, ow);
    write_reg(REG_OUT_H, oh);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int unsigned sw, sh, ow, oh, frames, len, pick, start_count;
    logic        mark_all;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset sizes, 1:1: color extremes and a restart mark mid-frame
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_random(1'b1);
    settle();

    // One-pixel frames wrap without a mark; shrink lands mid-frame
    set_sizes(1, 1, 1, 1);
    repeat (2) send_random(1'b0);
    settle();

    // Zero sizes saturate to one
    set_sizes(0, 0, 0, 0);
    repeat (2) send_random(1'b0);
    settle();

    // Upscale request saturates to the source size
    set_sizes(2, 2, 5, 7);
    for (int i = 0; i < 4; i++) send_random(i == 0);
    settle();

    // Oversized sizes saturate to the maximum
    set_sizes(8191, 8191, 8191, 8191);
    for (int i = 0; i < 2; i++) send_random(i == 0);
    settle();

    // Width shrinks below the current column
    set_sizes(3, 2, 2, 1);
    repeat (3) send_random(1'b0);
    settle();

    // Height shrinks below the current row
    set_sizes(1, 4000, 1, 4000);
    for (int i = 0; i < 4; i++) send_random(i == 0);
    settle();
    set_sizes(1, 2, 1, 2);
    repeat (2) send_random(1'b0);
    settle();

    // Random phases: mostly whole frames, some broken runs and large sizes
    start_count = pixels_sent;
    while (pixels_sent - start_count < RANDOM_ITEMS) begin
      if (pixels_sent - start_count < RANDOM_ITEMS / 3) begin
        send_idle_pct = 33;
        recv_stall_pct = 62;
      end else if (pixels_sent - start_count < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 62;
        recv_stall_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end

      pick = $urandom_range(99);
      if (pick < 8) begin
        // Large sizes: only a short partial frame
        set_sizes($urandom_range(8191), $urandom_range(1, 3),
                  $urandom_range(8191), $urandom_range(0, 3));
        len = $urandom_range(1, 20);
        for (int i = 0; i < len; i++) send_random(i == 0);
      end else begin
        sw = $urandom_range(0, 10);
        sh = $urandom_range(0, 6);
        ow = $urandom_range(0, 12);
        oh = $urandom_range(0, 8);
        set_sizes(sw, sh, ow, oh);
        if (pick < 85) begin
          // Whole frames, marked on the first pixel or left to wrap
          frames = $urandom_range(1, 3);
          len = ((sw == 0) ? 1 : sw) * ((sh == 0) ? 1 : sh);
          mark_all = 1'($urandom_range(1));
          for (int f = 0; f < frames; f++) begin
            for (int i = 0; i < len; i++) send_random(i == 0 && (f == 0 || mark_all));
          end
        end else begin
          // Broken run: stray marks and a partial frame
          len = $urandom_range(1, 20);
          for (int i = 0; i < len; i++) send_random($urandom_range(7) == 0);
        end
      end
      settle();
    end

    settle();
    if (mismatch_total == 0 && samples_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // End a hung run
  initial begin
    #1600000;
    $display("status: fail");
    $finish;
  end

endmodule
